// ===== src/well_pkg.sv =====
// Shared types and constants for the WELL44497a generator.
package well_pkg;

  localparam logic [31:0] MASK_UPPER  = 32'hFFFF_8000;
  localparam logic [31:0] MASK_LOWER  = 32'h0000_7FFF;
  localparam logic [31:0] TEMPER_KEEP = 32'hFBFF_FFFF;
  localparam logic [31:0] TEMPER_TEST = 32'h0002_0000;
  localparam logic [31:0] TEMPER_XOR  = 32'hB729_FCEC;
  localparam logic [31:0] SEED_MULT   = 32'd1812433253;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_SEED,
    OP_EXP_READ,
    OP_EXP_MUL,
    OP_EXP_WRITE,
    OP_DRAW_A,
    OP_DRAW_B,
    OP_DRAW_C,
    OP_DRAW_D,
    OP_DRAW_E,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   capture;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic expand_go;
    logic out_free;
  } status_t;

endpackage

// ===== src/well44497a_random_generator.sv =====
// Top level of the WELL44497a generator: stream ports, controller and datapath.
// Draw: states DRAW_A to DRAW_E make six reads and three writes on the pool memory
//   (one write and two read ports); no input is taken until the result is registered.
// Seed load: SEED per word; the last adds EXP_READ, EXP_MUL, EXP_WRITE per new entry.
// Reset: asynchronous, active low; a clearing pass then writes zero to all POOL_WORDS
//   entries, one a cycle, and no input is taken until it ends.
module well44497a_random_generator #(
  parameter int unsigned POOL_WORDS   = 1391,
  parameter int unsigned OFFSET_ONE   = 23,
  parameter int unsigned OFFSET_TWO   = 481,
  parameter int unsigned OFFSET_THREE = 229
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // [31:0] seed_word, [37:32] bits, [39:38] zero
  input  logic        s_tuser_i,   // req_type: 0 load seed word, 1 draw
  input  logic        s_tlast_i,   // seed_last
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o    // [31:0] value
);

  well_pkg::cmd_t    cmd;
  well_pkg::status_t status;

  // Sequence clearing, seeding, expansion and draw steps; accept only when idle.
  well_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tuser_i  (s_tuser_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the pool, pointers and output register; the output register lets the
  // next transfer in while a result still waits downstream.
  well_dp #(
    .POOL_WORDS   (POOL_WORDS),
    .OFFSET_ONE   (OFFSET_ONE),
    .OFFSET_TWO   (OFFSET_TWO),
    .OFFSET_THREE (OFFSET_THREE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .seed_word_i (s_tdata_i[31:0]),
    .seed_last_i (s_tlast_i),
    .bits_i      (s_tdata_i[37:32]),
    .m_tready_i  (m_tready_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tdata_o   (m_tdata_o)
  );

endmodule

// ===== src/well_dp.sv =====
// Datapath of the WELL44497a generator: pool memory, pointers, step and seed arithmetic.
module well_dp #(
  parameter int unsigned POOL_WORDS   = 1391,
  parameter int unsigned OFFSET_ONE   = 23,
  parameter int unsigned OFFSET_TWO   = 481,
  parameter int unsigned OFFSET_THREE = 229
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  well_pkg::cmd_t    cmd_i,
  output well_pkg::status_t status_o,
  input  logic [31:0]       seed_word_i,
  input  logic              seed_last_i,
  input  logic [5:0]        bits_i,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic [31:0]       m_tdata_o
);

  localparam int unsigned IW   = $clog2(POOL_WORDS);
  localparam int unsigned IW1  = IW + 1;
  localparam int unsigned CW   = $clog2(POOL_WORDS + 1);
  localparam int unsigned O1M  = OFFSET_ONE % POOL_WORDS;
  localparam int unsigned O2M  = OFFSET_TWO % POOL_WORDS;
  localparam int unsigned O3M  = OFFSET_THREE % POOL_WORDS;
  localparam int unsigned OM1  = POOL_WORDS - 1;
  localparam int unsigned OM2  = POOL_WORDS - 2;

  // Add an offset below the pool size and fold back into range.
  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [IW:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + off;
    if (s >= IW1'(POOL_WORDS)) s = s - IW1'(POOL_WORDS);
    return s[IW-1:0];
  endfunction

  logic [31:0] pool_mem [POOL_WORDS];
  logic [31:0] rdata_a_q, rdata_b_q;
  logic [IW-1:0] raddr_a, raddr_b, waddr;
  logic [31:0] wdata;
  logic        we;

  logic [IW-1:0] p_q, p_d, i_q, i_d, j_q, j_d;
  logic [CW-1:0] cnt_q, cnt_d, n_next;
  logic [31:0]   word_q;
  logic          last_q;
  logic [5:0]    bits_q;
  logic [31:0]   v0_q, vm1_q, z1_q, z2_q, z4_q, keep_q, prod_q;
  logic [31:0]   out_data_q;
  logic          out_valid_q;

  logic [IW-1:0] p1, p2, p3, rm1, rm2;
  logic [31:0]   z1_d, z2_d, z0_d, zt_d, z4_d, sx, value_d;
  logic [4:0]    shamt;
  logic          cnt_room, out_free, out_load;

  assign p1  = wrap_add(p_q, IW1'(O1M));
  assign p2  = wrap_add(p_q, IW1'(O2M));
  assign p3  = wrap_add(p_q, IW1'(O3M));
  assign rm1 = wrap_add(p_q, IW1'(OM1));
  assign rm2 = wrap_add(p_q, IW1'(OM2));

  assign cnt_room = cnt_q < CW'(POOL_WORDS);
  assign n_next   = cnt_room ? cnt_q + CW'(1) : cnt_q;

  // WELL step terms.
  assign z1_d = (v0_q ^ (v0_q << 24)) ^ (vm1_q ^ (vm1_q >> 30));
  assign z2_d = (rdata_a_q ^ (rdata_a_q << 10)) ^ (rdata_b_q << 26);
  assign z0_d = (well_pkg::MASK_UPPER & rdata_a_q) ^ (well_pkg::MASK_LOWER & rdata_b_q);
  always_comb begin
    zt_d = ((z2_q << 9) ^ (z2_q >> 23)) & well_pkg::TEMPER_KEEP;
    if ((z2_q & well_pkg::TEMPER_TEST) != 32'd0) zt_d = zt_d ^ well_pkg::TEMPER_XOR;
  end
  assign z4_d = z0_d ^ (z1_q ^ (z1_q >> 20)) ^ zt_d ^ (z1_q ^ z2_q);

  // Sign-extended shift by 30 for the seed expansion.
  assign sx = rdata_a_q ^ {{30{rdata_a_q[31]}}, rdata_a_q[31:30]};

  assign shamt = 5'(6'd32 - bits_q);
  always_comb begin
    if (bits_q == 6'd0)       value_d = 32'd0;
    else if (bits_q >= 6'd32) value_d = z4_q;
    else                      value_d = z4_q >> shamt;
  end

  assign out_free = !out_valid_q || m_tready_i;
  assign out_load = out_free &&
                    (cmd_i.op == well_pkg::OP_DRAW_E || cmd_i.op == well_pkg::OP_OUT);

  always_comb begin
    we      = 1'b0;
    waddr   = i_q;
    wdata   = 32'd0;
    raddr_a = j_q;
    raddr_b = rm2;
    unique case (cmd_i.op)
      well_pkg::OP_CLEAR: begin
        we = 1'b1;
      end
      well_pkg::OP_SEED: begin
        we    = cnt_room;
        waddr = cnt_q[IW-1:0];
        wdata = word_q;
      end
      well_pkg::OP_EXP_WRITE: begin
        we    = 1'b1;
        wdata = prod_q + 32'(i_q);
      end
      well_pkg::OP_DRAW_A: begin
        raddr_a = p_q;
        raddr_b = p1;
      end
      well_pkg::OP_DRAW_B: begin
        raddr_a = p2;
        raddr_b = p3;
      end
      well_pkg::OP_DRAW_C: begin
        raddr_a = rm1;
        raddr_b = rm2;
        we      = 1'b1;
        waddr   = p_q;
        wdata   = z1_d ^ z2_d;
      end
      well_pkg::OP_DRAW_D: begin
        we    = 1'b1;
        waddr = rm1;
        wdata = z4_d;
      end
      well_pkg::OP_DRAW_E: begin
        we    = 1'b1;
        waddr = rm2;
        wdata = keep_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) pool_mem[waddr] <= wdata;
    rdata_a_q <= pool_mem[raddr_a];
    rdata_b_q <= pool_mem[raddr_b];
  end

  // Pointers and counters.
  always_comb begin
    p_d   = p_q;
    i_d   = i_q;
    j_d   = j_q;
    cnt_d = cnt_q;
    unique case (cmd_i.op)
      well_pkg::OP_CLEAR: i_d = i_q + IW'(1);
      well_pkg::OP_SEED: begin
        cnt_d = n_next;
        if (last_q) begin
          cnt_d = '0;
          p_d   = '0;
          i_d   = n_next[IW-1:0];
          j_d   = '0;
        end
      end
      well_pkg::OP_EXP_WRITE: begin
        i_d = i_q + IW'(1);
        j_d = j_q + IW'(1);
      end
      well_pkg::OP_DRAW_E: p_d = rm1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      p_q   <= p_d;
      i_q   <= i_d;
      j_q   <= j_d;
      cnt_q <= cnt_d;
      if (out_load)        out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q <= seed_word_i;
      last_q <= seed_last_i;
      bits_q <= bits_i;
    end
    if (cmd_i.op == well_pkg::OP_EXP_MUL) prod_q <= well_pkg::SEED_MULT * sx;
    if (cmd_i.op == well_pkg::OP_DRAW_B) begin
      v0_q  <= rdata_a_q;
      vm1_q <= rdata_b_q;
    end
    if (cmd_i.op == well_pkg::OP_DRAW_C) begin
      z1_q <= z1_d;
      z2_q <= z2_d;
    end
    if (cmd_i.op == well_pkg::OP_DRAW_D) begin
      z4_q   <= z4_d;
      keep_q <= rdata_b_q & well_pkg::MASK_UPPER;
    end
    if (out_load) out_data_q <= value_d;
  end

  assign status_o.idx_last  = i_q == IW'(OM1);
  assign status_o.expand_go = last_q && (n_next < CW'(POOL_WORDS));
  assign status_o.out_free  = out_free;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

// ===== src/well_ctrl.sv =====
// Controller state machine of the WELL44497a generator.
module well_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tuser_i,
  output logic              s_tready_o,
  input  well_pkg::status_t status_i,
  output well_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED,
    ST_EXP_READ,
    ST_EXP_MUL,
    ST_EXP_WRITE,
    ST_DRAW_A,
    ST_DRAW_B,
    ST_DRAW_C,
    ST_DRAW_D,
    ST_DRAW_E,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   accept;

  assign s_tready_o    = state_q == ST_IDLE;
  assign accept        = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o.capture = accept;
    unique case (state_q)
      ST_CLEAR:     cmd_o.op = well_pkg::OP_CLEAR;
      ST_IDLE:      cmd_o.op = well_pkg::OP_NONE;
      ST_SEED:      cmd_o.op = well_pkg::OP_SEED;
      ST_EXP_READ:  cmd_o.op = well_pkg::OP_EXP_READ;
      ST_EXP_MUL:   cmd_o.op = well_pkg::OP_EXP_MUL;
      ST_EXP_WRITE: cmd_o.op = well_pkg::OP_EXP_WRITE;
      ST_DRAW_A:    cmd_o.op = well_pkg::OP_DRAW_A;
      ST_DRAW_B:    cmd_o.op = well_pkg::OP_DRAW_B;
      ST_DRAW_C:    cmd_o.op = well_pkg::OP_DRAW_C;
      ST_DRAW_D:    cmd_o.op = well_pkg::OP_DRAW_D;
      ST_DRAW_E:    cmd_o.op = well_pkg::OP_DRAW_E;
      ST_OUT:       cmd_o.op = well_pkg::OP_OUT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      unique case (state_q)
        ST_CLEAR:     if (status_i.idx_last) state_q <= ST_IDLE;
        ST_IDLE: begin
          if (accept) state_q <= (s_tuser_i == well_pkg::REQ_DRAW) ? ST_DRAW_A : ST_SEED;
        end
        ST_SEED:      state_q <= status_i.expand_go ? ST_EXP_READ : ST_IDLE;
        ST_EXP_READ:  state_q <= ST_EXP_MUL;
        ST_EXP_MUL:   state_q <= ST_EXP_WRITE;
        ST_EXP_WRITE: state_q <= status_i.idx_last ? ST_IDLE : ST_EXP_READ;
        ST_DRAW_A:    state_q <= ST_DRAW_B;
        ST_DRAW_B:    state_q <= ST_DRAW_C;
        ST_DRAW_C:    state_q <= ST_DRAW_D;
        ST_DRAW_D:    state_q <= ST_DRAW_E;
        ST_DRAW_E:    state_q <= status_i.out_free ? ST_IDLE : ST_OUT;
        ST_OUT:       if (status_i.out_free) state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
